// ----- src/assert_macros.svh -----
// assertion helpers for the slot scheduler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst, prop, msg)

`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ----- src/tss_pkg.sv -----
package tss_pkg;

   localparam int DIV_WIDTH       = 64;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_WIDTH + 1);
   localparam int INTERVAL_WIDTH  = 42;

   localparam logic [9:0] US_PER_MS = 10'd1000;
   localparam logic [7:0] NO_PIN    = 8'hFF;

   localparam logic [2:0] CSR_FIRST_OWN_SLOT   = 3'd0;
   localparam logic [2:0] CSR_OWN_SLOT_COUNT   = 3'd1;
   localparam logic [2:0] CSR_FRAME_SLOT_COUNT = 3'd2;
   localparam logic [2:0] CSR_SLOT_LENGTH_MS   = 3'd3;
   localparam logic [2:0] CSR_ONE_FRAME_ONLY   = 3'd4;

   typedef enum logic [1:0] {
      REQ_START   = 2'd0,
      REQ_STOP    = 2'd1,
      REQ_PROCESS = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_NONE       = 3'd0,
      STAT_SLOT       = 3'd1,
      STAT_FRAME_DONE = 3'd2,
      STAT_STARTED    = 3'd3,
      STAT_REFUSED    = 3'd4,
      STAT_STOPPED    = 3'd5,
      STAT_ALREADY    = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0] first_own_slot;
      logic [7:0]  own_slot_count;
      logic [15:0] frame_slot_count;
      logic [31:0] slot_length_ms;
      logic        one_frame_only;
      logic        valid;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic [15:0] slot;
      logic        active;
      logic [7:0]  pin;
   } slot_info_type;

   function automatic slot_info_type select_slot(input logic [15:0] slot,
                                                 input logic [15:0] first,
                                                 input logic [7:0]  count);
      slot_info_type info;
      logic [16:0]   limit;
      limit       = {1'b0, first} + {9'b0, count};
      info.slot   = slot;
      info.active = (slot >= first) && ({1'b0, slot} < limit);
      info.pin    = info.active ? 8'(slot - first) : NO_PIN;
      return info;
   endfunction

endpackage

// ----- src/tss_cfg.sv -----
module tss_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic                 running,
   output tss_pkg::cfg_type     cfg
);

   logic [15:0] first_ff, first_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] frame_ff, frame_in;
   logic [31:0] length_ff, length_in;
   logic        one_frame_ff, one_frame_in;
   logic [16:0] own_end;

   always_comb begin
      first_in     = first_ff;
      count_in     = count_ff;
      frame_in     = frame_ff;
      length_in    = length_ff;
      one_frame_in = one_frame_ff;
      // configuration is frozen for the length of a run
      if (csr_write_enable && !running) begin
         unique case (csr_index)
            tss_pkg::CSR_FIRST_OWN_SLOT:   first_in     = csr_write_data[15:0];
            tss_pkg::CSR_OWN_SLOT_COUNT:   count_in     = csr_write_data[7:0];
            tss_pkg::CSR_FRAME_SLOT_COUNT: frame_in     = csr_write_data[15:0];
            tss_pkg::CSR_SLOT_LENGTH_MS:   length_in    = csr_write_data;
            tss_pkg::CSR_ONE_FRAME_ONLY:   one_frame_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         count_ff     <= '0;
         frame_ff     <= '0;
         length_ff    <= '0;
         one_frame_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         count_ff     <= count_in;
         frame_ff     <= frame_in;
         length_ff    <= length_in;
         one_frame_ff <= one_frame_in;
      end
   end

   assign own_end = {1'b0, first_ff} + {9'b0, count_ff};

   assign cfg.first_own_slot   = first_ff;
   assign cfg.own_slot_count   = count_ff;
   assign cfg.frame_slot_count = frame_ff;
   assign cfg.slot_length_ms   = length_ff;
   assign cfg.one_frame_only   = one_frame_ff;
   assign cfg.valid = (count_ff != '0) && (frame_ff != '0) && (length_ff != '0) &&
                      (first_ff < frame_ff) && (own_end <= {1'b0, frame_ff});

endmodule

// ----- src/tss_divider.sv -----
module tss_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tss_pkg::DIV_WIDTH-1:0]       dividend,
   input  logic [tss_pkg::DIV_WIDTH-1:0]       divisor,
   output tss_pkg::div_stat_type               stat,
   output logic [tss_pkg::DIV_WIDTH-1:0]       quotient,
   output logic [tss_pkg::DIV_WIDTH-1:0]       remainder
);

   localparam int W  = tss_pkg::DIV_WIDTH;
   localparam int CW = tss_pkg::DIV_COUNT_WIDTH;

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          fits;

   // restoring division, one quotient bit per cycle, msb first
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in  = {quo_ff[W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/tdma_slot_scheduler.sv -----
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_type, req_time_us
// rsp       out        rsp_valid / rsp_ready  rsp_status, rsp_slot_number, rsp_slot_active,
//                                             rsp_active_pin, rsp_running
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// start, stop and the first tick after a start go from accept straight to S_RESP, with no divide
// a slot tick makes two 64-step passes of the shared divider
// (elapsed / interval, then quotient mod frame size) plus multiply and update
// reset is synchronous; the scheduler comes up stopped with slot 0 selected
// req_ready is low while a request is in work; a response waiting on rsp_ready
// holds back the next response only, not the next accept
`include "assert_macros.svh"

module tdma_slot_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_time_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_slot_number,
   output logic        rsp_slot_active,
   output logic [7:0]  rsp_active_pin,
   output logic        rsp_running,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int W  = tss_pkg::DIV_WIDTH;
   localparam int IW = tss_pkg::INTERVAL_WIDTH;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL    = 8'b0000_0010,
      S_QSTART = 8'b0000_0100,
      S_QWAIT  = 8'b0000_1000,
      S_SSTART = 8'b0001_0000,
      S_SWAIT  = 8'b0010_0000,
      S_EVAL   = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic                    is_running_ff, is_running_in;
   logic                    first_pending_ff, first_pending_in;
   logic                    frame_done_ff, frame_done_in;
   logic [63:0]             origin_ff, origin_in;
   logic [63:0]             elapsed_ff, elapsed_in;
   logic [IW-1:0]           interval_ff, interval_in;
   logic [W-1:0]            quot_ff, quot_in;
   logic [15:0]             slot_calc_ff, slot_calc_in;
   tss_pkg::slot_info_type  slot_info_ff, slot_info_in;
   tss_pkg::status_type     status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   tss_pkg::status_type     rsp_status_ff, rsp_status_in;
   tss_pkg::slot_info_type  rsp_info_ff, rsp_info_in;
   logic                    rsp_running_ff, rsp_running_in;

   tss_pkg::cfg_type        cfg;
   tss_pkg::div_stat_type   div_stat;
   logic                    div_start;
   logic [W-1:0]            div_dividend;
   logic [W-1:0]            div_divisor;
   logic [W-1:0]            div_quotient;
   logic [W-1:0]            div_remainder;

   tss_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .running          (is_running_ff),
      .cfg              (cfg)
   );

   tss_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in         = state_ff;
      is_running_in    = is_running_ff;
      first_pending_in = first_pending_ff;
      frame_done_in    = frame_done_ff;
      origin_in        = origin_ff;
      elapsed_in       = elapsed_ff;
      interval_in      = interval_ff;
      quot_in          = quot_ff;
      slot_calc_in     = slot_calc_ff;
      slot_info_in     = slot_info_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_info_in      = rsp_info_ff;
      rsp_running_in   = rsp_running_ff;
      div_start        = 1'b0;
      div_dividend     = elapsed_ff;
      div_divisor      = W'(interval_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = tss_pkg::STAT_NONE;
               state_in  = S_RESP;
               case (req_type)
                  tss_pkg::REQ_START: begin
                     if (!cfg.valid) begin
                        status_in = tss_pkg::STAT_REFUSED;
                     end else if (is_running_ff) begin
                        status_in = tss_pkg::STAT_ALREADY;
                     end else begin
                        is_running_in    = 1'b1;
                        first_pending_in = 1'b1;
                        frame_done_in    = 1'b0;
                        origin_in        = req_time_us;
                        slot_info_in     = tss_pkg::select_slot(16'd0, cfg.first_own_slot,
                                                                cfg.own_slot_count);
                        status_in        = tss_pkg::STAT_STARTED;
                     end
                  end
                  tss_pkg::REQ_STOP: begin
                     if (is_running_ff) begin
                        is_running_in = 1'b0;
                        status_in     = tss_pkg::STAT_STOPPED;
                     end
                  end
                  tss_pkg::REQ_PROCESS: begin
                     if (is_running_ff) begin
                        if (first_pending_ff) begin
                           first_pending_in = 1'b0;
                           status_in        = tss_pkg::STAT_SLOT;
                        end else begin
                           // wraps when the time is before the origin
                           elapsed_in = req_time_us - origin_ff;
                           state_in   = S_MUL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            interval_in = IW'(cfg.slot_length_ms) * tss_pkg::US_PER_MS;
            state_in    = S_QSTART;
         end
         S_QSTART: begin
            div_start = 1'b1;
            state_in  = S_QWAIT;
         end
         S_QWAIT: begin
            if (div_stat.done) begin
               quot_in  = (interval_ff == '0) ? '0 : div_quotient;
               state_in = S_SSTART;
            end
         end
         S_SSTART: begin
            div_start    = 1'b1;
            div_dividend = quot_ff;
            div_divisor  = W'(cfg.frame_slot_count);
            state_in     = S_SWAIT;
         end
         S_SWAIT: begin
            if (div_stat.done) begin
               slot_calc_in = (cfg.frame_slot_count == '0) ? 16'd0 : div_remainder[15:0];
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in  = S_RESP;
            status_in = tss_pkg::STAT_NONE;
            if (cfg.one_frame_only && !frame_done_ff &&
                (quot_ff >= W'(cfg.frame_slot_count))) begin
               frame_done_in = 1'b1;
               is_running_in = 1'b0;
               status_in     = tss_pkg::STAT_FRAME_DONE;
            end else if (slot_calc_ff != slot_info_ff.slot) begin
               slot_info_in = tss_pkg::select_slot(slot_calc_ff, cfg.first_own_slot,
                                                   cfg.own_slot_count);
               status_in    = tss_pkg::STAT_SLOT;
            end
         end
         S_RESP: begin
            // wait here only while the previous response is still unclaimed
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_info_in    = slot_info_ff;
               rsp_running_in = is_running_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         is_running_ff    <= 1'b0;
         first_pending_ff <= 1'b1;
         frame_done_ff    <= 1'b0;
         slot_info_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         is_running_ff    <= is_running_in;
         first_pending_ff <= first_pending_in;
         frame_done_ff    <= frame_done_in;
         slot_info_ff     <= slot_info_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      origin_ff      <= origin_in;
      elapsed_ff     <= elapsed_in;
      interval_ff    <= interval_in;
      quot_ff        <= quot_in;
      slot_calc_ff   <= slot_calc_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_info_ff    <= rsp_info_in;
      rsp_running_ff <= rsp_running_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_number = rsp_info_ff.slot;
   assign rsp_slot_active = rsp_info_ff.active;
   assign rsp_active_pin  = rsp_info_ff.pin;
   assign rsp_running     = rsp_running_ff;

   `ASSERT_PROP(a_div_quiet_in_idle, clock, reset, (state_ff == S_IDLE) |-> !div_stat.busy, "divider busy while idle")
   `ASSERT_PROP(a_div_only_running, clock, reset, (state_ff == S_QWAIT || state_ff == S_SWAIT) |-> is_running_ff, "slot divide while stopped")
   `ASSERT_PROP(a_frame_done_stops, clock, reset, $rose(frame_done_ff) |-> !is_running_ff, "frame done left scheduler running")
   `ASSERT_PROP(a_slot_in_frame, clock, reset, is_running_ff |-> (slot_info_ff.slot < cfg.frame_slot_count), "current slot outside frame")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] REQ_SPARE  = 2'd3;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      tss_pkg::status_type status;
      logic [15:0]         slot;
      logic                active;
      logic [7:0]          pin;
      logic                running;
   } slot_report_type;

   // tracks the scheduler state and the responses still owed
   class slot_scoreboard;
      logic [15:0]     first_slot;
      logic [7:0]      own_count;
      logic [15:0]     frame_size;
      logic [31:0]     slot_ms;
      logic            single_frame;
      logic            running;
      logic            awaiting_first;
      logic            frame_finished;
      logic [63:0]     origin_us;
      logic [15:0]     cur_slot;
      logic            cur_active;
      logic [7:0]      cur_pin;
      slot_report_type expected_q[$];
      int              error_count;
      int              checked_count;
      int              kind_count[4];
      int              announce_count;
      int              finish_count;

      function new();
         first_slot     = '0;
         own_count      = '0;
         frame_size     = '0;
         slot_ms        = '0;
         single_frame   = 1'b0;
         running        = 1'b0;
         awaiting_first = 1'b1;
         frame_finished = 1'b0;
         origin_us      = '0;
         cur_slot       = '0;
         cur_active     = 1'b0;
         cur_pin        = '0;
         error_count    = 0;
         checked_count  = 0;
         announce_count = 0;
         finish_count   = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      // writes are dropped while the scheduler runs
      function void write_reg(input logic [2:0] idx, input logic [31:0] data);
         if (running) return;
         case (idx)
            tss_pkg::CSR_FIRST_OWN_SLOT:   first_slot   = data[15:0];
            tss_pkg::CSR_OWN_SLOT_COUNT:   own_count    = data[7:0];
            tss_pkg::CSR_FRAME_SLOT_COUNT: frame_size   = data[15:0];
            tss_pkg::CSR_SLOT_LENGTH_MS:   slot_ms      = data;
            tss_pkg::CSR_ONE_FRAME_ONLY:   single_frame = data[0];
            default: ;
         endcase
      endfunction

      function bit config_ok();
         return own_count != 0 && frame_size != 0 && slot_ms != 0 &&
                first_slot < frame_size &&
                ({1'b0, first_slot} + 17'(own_count)) <= {1'b0, frame_size};
      endfunction

      function void take_slot(input logic [15:0] s);
         cur_slot   = s;
         cur_active = s >= first_slot && {1'b0, s} < {1'b0, first_slot} + 17'(own_count);
         cur_pin    = cur_active ? 8'(s - first_slot) : tss_pkg::NO_PIN;
      endfunction

      function void note_request(input logic [1:0] kind, input logic [63:0] t);
         slot_report_type want;
         logic [63:0]     interval;
         logic [63:0]     quot;
         logic [63:0]     slot_sel;
         want.status = tss_pkg::STAT_NONE;
         kind_count[kind]++;
         case (kind)
            tss_pkg::REQ_START: begin
               if (!config_ok()) begin
                  want.status = tss_pkg::STAT_REFUSED;
               end else if (running) begin
                  want.status = tss_pkg::STAT_ALREADY;
               end else begin
                  running        = 1'b1;
                  awaiting_first = 1'b1;
                  frame_finished = 1'b0;
                  origin_us      = t;
                  take_slot('0);
                  want.status    = tss_pkg::STAT_STARTED;
               end
            end
            tss_pkg::REQ_STOP: begin
               if (running) begin
                  running     = 1'b0;
                  want.status = tss_pkg::STAT_STOPPED;
               end
            end
            tss_pkg::REQ_PROCESS: begin
               if (running && awaiting_first) begin
                  awaiting_first = 1'b0;
                  want.status    = tss_pkg::STAT_SLOT;
               end else if (running) begin
                  interval = 64'(slot_ms) * 64'(tss_pkg::US_PER_MS);
                  // elapsed time wraps when the tick is older than the start
                  quot     = (interval == 0) ? '0 : (t - origin_us) / interval;
                  slot_sel = (frame_size == 0) ? '0 : quot % 64'(frame_size);
                  if (single_frame && !frame_finished && quot >= 64'(frame_size)) begin
                     frame_finished = 1'b1;
                     running        = 1'b0;
                     want.status    = tss_pkg::STAT_FRAME_DONE;
                  end else if (slot_sel != 64'(cur_slot)) begin
                     take_slot(slot_sel[15:0]);
                     want.status = tss_pkg::STAT_SLOT;
                  end
               end
            end
            default: ;
         endcase
         if (want.status == tss_pkg::STAT_SLOT) announce_count++;
         if (want.status == tss_pkg::STAT_FRAME_DONE) finish_count++;
         want.slot    = cur_slot;
         want.active  = cur_active;
         want.pin     = cur_pin;
         want.running = running;
         expected_q.push_back(want);
      endfunction

      task report(input string what);
         error_count++;
         if (error_count <= 40) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_response(input logic [2:0] got_status, input logic [15:0] got_slot,
                          input logic got_active, input logic [7:0] got_pin,
                          input logic got_running);
         slot_report_type want;
         checked_count++;
         if (expected_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got_status !== want.status)
            report($sformatf("status %0d, want %0d", got_status, want.status));
         if (got_slot !== want.slot)
            report($sformatf("slot_number %0d, want %0d", got_slot, want.slot));
         if (got_active !== want.active)
            report($sformatf("slot_active %0b, want %0b", got_active, want.active));
         if (got_pin !== want.pin)
            report($sformatf("active_pin %0d, want %0d", got_pin, want.pin));
         if (got_running !== want.running)
            report($sformatf("running %0b, want %0b", got_running, want.running));
      endtask
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type         = '0;
   logic [63:0] req_time_us      = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_slot_number;
   logic        rsp_slot_active;
   logic [7:0]  rsp_active_pin;
   logic        rsp_running;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [31:0] csr_write_data   = '0;

   slot_scoreboard sb;
   bit sender_gaps = 1'b1;
   bit rsp_gaps    = 1'b1;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int cfg_count   = 0;

   tdma_slot_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_slot_active  (rsp_slot_active),
      .rsp_active_pin   (rsp_active_pin),
      .rsp_running      (rsp_running),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_slot_number, rsp_slot_active,
                              rsp_active_pin, rsp_running);
         // long back-pressure window, counted here
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_gaps && $urandom_range(99) < 21);
         end
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [63:0] t);
      if (sender_gaps && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 21);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_time_us <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, t);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_config(input logic [31:0] first, input logic [31:0] count,
                                 input logic [31:0] frame, input logic [31:0] len,
                                 input logic [31:0] one, input bit stray);
      logic [31:0] vals[6];
      logic [2:0]  idxs[6];
      int          start_at;
      // registers only change with no request in flight
      wait_idle();
      vals = '{$urandom, first, count, frame, len, one};
      idxs = '{CSR_UNUSED, tss_pkg::CSR_FIRST_OWN_SLOT, tss_pkg::CSR_OWN_SLOT_COUNT,
               tss_pkg::CSR_FRAME_SLOT_COUNT, tss_pkg::CSR_SLOT_LENGTH_MS,
               tss_pkg::CSR_ONE_FRAME_ONLY};
      start_at = stray ? 0 : 1;
      cfg_count++;
      csr_write_enable <= 1'b1;
      for (int i = start_at; i < 6; i++) begin
         csr_index      <= idxs[i];
         csr_write_data <= vals[i];
         @(posedge clock);
         sb.write_reg(idxs[i], vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input int n_items);
      logic [31:0] first;
      logic [31:0] count;
      logic [31:0] frame;
      logic [31:0] len;
      logic [63:0] interval;
      logic [63:0] elapsed;
      logic [63:0] t;
      int          pick;
      int          room;
      wait_idle();
      pick = $urandom_range(99);
      if (pick < 70) begin
         frame = $urandom_range(1, 12);
         first = $urandom_range(0, frame - 1);
         count = $urandom_range(1, frame - first);
         len   = $urandom_range(1, 3);
         // upper bits beyond the register width must be dropped
         if ($urandom_range(3) == 0) first = first | ($urandom & 32'hFFFF_0000);
         if ($urandom_range(3) == 0) count = count | ($urandom & 32'hFFFF_FF00);
      end else if (pick < 82) begin
         frame = $urandom_range(256, 65535);
         first = $urandom_range(0, frame - 1);
         room  = (frame - first > 255) ? 255 : int'(frame - first);
         count = $urandom_range(1, room);
         len   = $urandom;
         if (len == 0) len = 1;
      end else if (pick < 92) begin
         first = $urandom_range(0, 15);
         count = $urandom_range(0, 12);
         frame = $urandom_range(0, 16);
         len   = $urandom_range(0, 2);
      end else begin
         first = $urandom;
         count = $urandom;
         frame = $urandom;
         len   = $urandom;
      end
      program_config(first, count, frame, len, $urandom, $urandom_range(7) == 0);
      elapsed = '0;
      for (int i = 0; i < n_items; i++) begin
         pick     = $urandom_range(99);
         interval = 64'(sb.slot_ms) * 64'(tss_pkg::US_PER_MS);
         if ((!sb.running && pick < 80 && $urandom_range(3) != 0) ||
             (pick >= 91 && pick < 96)) begin
            t = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom);
            send_request(tss_pkg::REQ_START, t);
            if (sb.origin_us == t) elapsed = '0;
         end else if (pick < 80) begin
            case ($urandom_range(19))
               0:       elapsed = elapsed + interval * 64'(sb.frame_size);
               1:       elapsed = elapsed + 64'($urandom);
               default: elapsed = elapsed + interval * 64'($urandom_range(0, 300)) / 64'd200;
            endcase
            send_request(tss_pkg::REQ_PROCESS, sb.origin_us + elapsed);
         end else if (pick < 84) begin
            send_request(tss_pkg::REQ_PROCESS, {$urandom, $urandom});
         end else if (pick < 87) begin
            send_request(tss_pkg::REQ_PROCESS, sb.origin_us - 64'($urandom_range(1, 5000)));
         end else if (pick < 91) begin
            send_request(tss_pkg::REQ_STOP, {$urandom, $urandom});
         end else begin
            send_request(REQ_SPARE, {$urandom, $urandom});
         end
      end
   endtask

   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [63:0] t0;
      logic [63:0] span;
      logic [1:0]  kind;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all registers zero after reset: starts are refused
      send_request(tss_pkg::REQ_START, 64'd12345);
      send_request(REQ_SPARE, 64'd0);

      // broken configurations
      program_config(0, 0, 8, 1, 0, 0);
      send_request(tss_pkg::REQ_START, 64'd100);
      program_config(8, 1, 8, 1, 0, 0);
      send_request(tss_pkg::REQ_START, 64'd100);
      program_config(6, 3, 8, 1, 0, 0);
      send_request(tss_pkg::REQ_START, 64'd100);
      program_config(2, 3, 8, 0, 0, 0);
      send_request(tss_pkg::REQ_START, 64'd100);

      // small continuous frame, 1 ms slots
      program_config(2, 3, 8, 1, 0, 0);
      t0 = 64'h0000_0000_0010_0000;
      send_request(tss_pkg::REQ_PROCESS, t0);
      send_request(tss_pkg::REQ_START, t0);
      send_request(tss_pkg::REQ_START, t0 + 64'd7);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd5);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd500);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd2000);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd4999);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd5000);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd9000);
      send_request(tss_pkg::REQ_PROCESS, t0 - 64'd1);
      send_request(REQ_SPARE, t0);
      // dropped while running, old settings stay
      wait_idle();
      program_config(9, 0, 4, 0, 1, 0);
      send_request(tss_pkg::REQ_PROCESS, t0 + 64'd3000);
      send_request(tss_pkg::REQ_STOP, t0);
      send_request(tss_pkg::REQ_STOP, t0);

      // widest frame, longest slot, single frame, origin at the top of time
      wait_idle();
      program_config(65280, 255, 65535, 32'hFFFF_FFFF, 1, 1);
      span = 64'(32'hFFFF_FFFF) * 64'(tss_pkg::US_PER_MS);
      t0   = '1;
      send_request(tss_pkg::REQ_START, t0);
      send_request(tss_pkg::REQ_PROCESS, t0);
      send_request(tss_pkg::REQ_PROCESS, t0 + span * 64'd65279);
      send_request(tss_pkg::REQ_PROCESS, t0 + span * 64'd65280);
      send_request(tss_pkg::REQ_PROCESS, t0 + span * 64'd65534 + span - 64'd1);
      send_request(tss_pkg::REQ_PROCESS, t0 + span * 64'd65535);
      send_request(tss_pkg::REQ_PROCESS, t0 + span * 64'd65536);

      for (int phase = 0; phase < 40; phase++) begin
         sender_gaps = !(phase >= 8 && phase < 14);
         rsp_gaps   <= !(phase >= 8 && phase < 14);
         if (phase == 20) begin
            // stall the response side while fast requests keep coming
            wait_idle();
            program_config(2, 3, 8, 1, 0, 0);
            send_request(tss_pkg::REQ_START, 64'd0);
            hold_token  <= hold_token + 1;
            sender_gaps = 1'b0;
            for (int i = 0; i < 40; i++) begin
               case ($urandom_range(2))
                  0:       kind = tss_pkg::REQ_START;
                  1:       kind = tss_pkg::REQ_STOP;
                  default: kind = REQ_SPARE;
               endcase
               send_request(kind, {$urandom, $urandom});
            end
            sender_gaps = 1'b1;
         end
         random_phase($urandom_range(20, 45));
      end

      wait_idle();
      repeat (150) @(posedge clock);
      $display("covered %0d requests (%0d start, %0d stop, %0d tick, %0d spare)",
               sb.kind_count[tss_pkg::REQ_START] + sb.kind_count[tss_pkg::REQ_STOP] +
               sb.kind_count[tss_pkg::REQ_PROCESS] + sb.kind_count[REQ_SPARE],
               sb.kind_count[tss_pkg::REQ_START], sb.kind_count[tss_pkg::REQ_STOP],
               sb.kind_count[tss_pkg::REQ_PROCESS], sb.kind_count[REQ_SPARE]);
      $display("%0d settings, %0d responses checked, %0d slot announcements, %0d finishes",
               cfg_count, sb.checked_count, sb.announce_count, sb.finish_count);
      if (sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
